[rtl/rlc_pkg.sv]
`default_nettype none

package rlc_pkg;

    localparam int LETTERS     = 26;
    localparam int WIRINGS     = 5;
    localparam int ROTOR_TYPES = 5;
    localparam int ROT_AVAIL   = (ROTOR_TYPES < WIRINGS) ? ROTOR_TYPES : WIRINGS;
    localparam logic [2:0] ROT_LAST = 3'(ROT_AVAIL - 1);

    typedef logic [4:0] t_letter;
    typedef logic [2:0] t_wire_sel;
    typedef logic [LETTERS-1:0][4:0] t_perm;
    typedef logic [WIRINGS-1:0][LETTERS-1:0][4:0] t_perm_set;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_ROT0 = 3'd0,
        CFG_ROT1 = 3'd1,
        CFG_ROT2 = 3'd2,
        CFG_POS0 = 3'd3,
        CFG_POS1 = 3'd4,
        CFG_POS2 = 3'd5
    } t_cfg_index;

    // wiring choice and current position of each slot
    typedef struct packed {
        t_wire_sel w0;
        t_wire_sel w1;
        t_wire_sel w2;
        t_letter   p0;
        t_letter   p1;
        t_letter   p2;
    } t_rotor_set;

    function automatic t_perm f_perm_from_str(input logic [8*LETTERS-1:0] s);
        t_perm      t;
        logic [7:0] c;
        t = '0;
        for (int i = 0; i < LETTERS; i++) begin
            c    = s[(LETTERS-1-i)*8 +: 8];
            t[i] = 5'(c - 8'd65);
        end
        return t;
    endfunction

    function automatic t_perm f_invert(input t_perm p);
        t_perm inv;
        inv = '0;
        for (int j = 0; j < LETTERS; j++) begin
            inv[p[j]] = 5'(j);
        end
        return inv;
    endfunction

    localparam t_perm WIRE_0  = f_perm_from_str("EKMFLGDQVZNTOWYHXUSPAIBRCJ");
    localparam t_perm WIRE_1  = f_perm_from_str("AJDKSIRUXBLHWTMCQGZNPYFVOE");
    localparam t_perm WIRE_2  = f_perm_from_str("BDFHJLCPRTXVZNYEIWGAKMUSQO");
    localparam t_perm WIRE_3  = f_perm_from_str("ESOVPZJAYQUIRHXLNFTGKDCMWB");
    localparam t_perm WIRE_4  = f_perm_from_str("VZBRGITYUPSDNHLXAWMJQOFECK");
    localparam t_perm REFLECT = f_perm_from_str("EJMZALYXVBWFCRQUONTSPIKHGD");
    localparam t_perm PLUG    = f_perm_from_str("ZYXWVUTSRQKLMNOPJIHGFEDCBA");

    localparam t_perm_set WIRE_FWD = {WIRE_4, WIRE_3, WIRE_2, WIRE_1, WIRE_0};
    localparam t_perm_set WIRE_INV = {f_invert(WIRE_4), f_invert(WIRE_3),
                                      f_invert(WIRE_2), f_invert(WIRE_1),
                                      f_invert(WIRE_0)};

    // fold 26..31 back into the alphabet
    function automatic t_letter f_wrap26(input t_letter v);
        return (v >= 5'(LETTERS)) ? 5'(v - 5'(LETTERS)) : v;
    endfunction

    function automatic t_letter f_add26(input t_letter a, input t_letter b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 6'(LETTERS)) ? 5'(s - 6'(LETTERS)) : s[4:0];
    endfunction

    function automatic t_letter f_sub26(input t_letter a, input t_letter b);
        return (a >= b) ? 5'(a - b) : 5'(a + 5'(LETTERS) - b);
    endfunction

    function automatic t_wire_sel f_pick(input t_wire_sel c);
        return (c >= 3'(ROT_AVAIL)) ? ROT_LAST : c;
    endfunction

endpackage

`default_nettype wire

[rtl/rlc_settings.sv]
`default_nettype none

module rlc_settings (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [4:0]           i_cfg_data,
    input  wire logic                 i_step,
    output rlc_pkg::t_rotor_set       o_rotors
);

    rlc_pkg::t_rotor_set r_rot, n_rot;
    rlc_pkg::t_letter    pos0_inc, pos1_inc, pos2_inc;
    rlc_pkg::t_letter    data_wrap;

    assign pos0_inc  = rlc_pkg::f_add26(r_rot.p0, 5'd1);
    assign pos1_inc  = rlc_pkg::f_add26(r_rot.p1, 5'd1);
    assign pos2_inc  = rlc_pkg::f_add26(r_rot.p2, 5'd1);
    assign data_wrap = rlc_pkg::f_wrap26(i_cfg_data);

    always_comb begin
        n_rot = r_rot;
        // odometer stepping, fastest slot always moves
        if (i_step) begin
            n_rot.p0 = pos0_inc;
            if (pos0_inc == 5'd0) begin
                n_rot.p1 = pos1_inc;
                if (pos1_inc == 5'd0) begin
                    n_rot.p2 = pos2_inc;
                end
            end
        end
        if (i_cfg_we) begin
            case (rlc_pkg::t_cfg_index'(i_cfg_index))
                rlc_pkg::CFG_ROT0: n_rot.w0 = rlc_pkg::f_pick(i_cfg_data[2:0]);
                rlc_pkg::CFG_ROT1: n_rot.w1 = rlc_pkg::f_pick(i_cfg_data[2:0]);
                rlc_pkg::CFG_ROT2: n_rot.w2 = rlc_pkg::f_pick(i_cfg_data[2:0]);
                rlc_pkg::CFG_POS0: n_rot.p0 = data_wrap;
                rlc_pkg::CFG_POS1: n_rot.p1 = data_wrap;
                rlc_pkg::CFG_POS2: n_rot.p2 = data_wrap;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot.w0 <= rlc_pkg::f_pick(3'd0);
            r_rot.w1 <= rlc_pkg::f_pick(3'd1);
            r_rot.w2 <= rlc_pkg::f_pick(3'd2);
            r_rot.p0 <= 5'd0;
            r_rot.p1 <= 5'd0;
            r_rot.p2 <= 5'd0;
        end else begin
            r_rot <= n_rot;
        end
    end

    assign o_rotors = r_rot;

endmodule

`default_nettype wire

[rtl/rlc_core.sv]
`default_nettype none

module rlc_core (
    input  wire rlc_pkg::t_letter     i_letter,
    input  wire rlc_pkg::t_rotor_set  i_rotors,
    output rlc_pkg::t_letter          o_letter
);

    rlc_pkg::t_letter a_plug, f0, f1, f2, a_refl, b2, b1, b0;

    always_comb begin
        a_plug = rlc_pkg::PLUG[i_letter];
        f0 = rlc_pkg::WIRE_FWD[i_rotors.w0][rlc_pkg::f_add26(a_plug, i_rotors.p0)];
        f1 = rlc_pkg::WIRE_FWD[i_rotors.w1][rlc_pkg::f_add26(f0, i_rotors.p1)];
        f2 = rlc_pkg::WIRE_FWD[i_rotors.w2][rlc_pkg::f_add26(f1, i_rotors.p2)];
        a_refl = rlc_pkg::REFLECT[f2];
        // return path: inverse wiring, then take the position back off
        b2 = rlc_pkg::f_sub26(rlc_pkg::WIRE_INV[i_rotors.w2][a_refl], i_rotors.p2);
        b1 = rlc_pkg::f_sub26(rlc_pkg::WIRE_INV[i_rotors.w1][b2], i_rotors.p1);
        b0 = rlc_pkg::f_sub26(rlc_pkg::WIRE_INV[i_rotors.w0][b1], i_rotors.p0);
        o_letter = rlc_pkg::PLUG[b0];
    end

endmodule

`default_nettype wire

[rtl/three_rotor_letter_cipher.sv]
// three-rotor letter cipher, one letter word in, one cipher letter word out
// input channel: i_in_valid / o_in_stall carry i_plain_letter (0..25, 26..31
//   fold back by 26); a word is taken on a clock edge with valid high and
//   stall low
// output channel: o_out_valid / i_out_stall carry o_cipher_letter
// configuration: i_cfg_we writes register i_cfg_index with i_cfg_data:
//   0..2 pick the wiring of the fast, middle and slow slot, 3..5 load the
//   start position of those slots; indexes 6 and 7 are ignored
// write configuration only while no word is in flight
// path: an accepted word is held in the input stage register, then registered in the output register
// throughput: one word per cycle while the output is not stalled; the whole cipher path is one layer of logic
//   between the input stage register and the output register
// the rotor positions step on every accepted word, so words are encoded in
//   order with the positions current at their acceptance
// reset (i_rst_n low, synchronous) empties both stages and loads wirings
//   0, 1, 2 with all positions at 0
// a stalled output holds its word; the input stage still fills behind it, and
//   o_in_stall rises only once both stages are full and the output is stalled
`default_nettype none

module three_rotor_letter_cipher (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [4:0]           i_plain_letter,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [4:0]                o_cipher_letter,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [4:0]           i_cfg_data
);

    logic                r_s1_valid;
    rlc_pkg::t_letter    r_s1_letter;
    rlc_pkg::t_rotor_set r_s1_rot;
    logic                r_out_valid;
    rlc_pkg::t_letter    r_out_letter;

    rlc_pkg::t_rotor_set rotors;
    rlc_pkg::t_letter    core_letter;
    logic                in_acc, s1_adv;

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    rlc_settings u_settings (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (in_acc),
        .o_rotors    (rotors)
    );

    rlc_core u_core (
        .i_letter (r_s1_letter),
        .i_rotors (r_s1_rot),
        .o_letter (core_letter)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= in_acc || (r_s1_valid && !s1_adv);
            r_out_valid <= s1_adv || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_letter <= rlc_pkg::f_wrap26(i_plain_letter);
            r_s1_rot    <= rotors;
        end
        if (s1_adv) begin
            r_out_letter <= core_letter;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cipher_letter = r_out_letter;

`ifndef SYNTH
    a_acc_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted word did not reach the input stage");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rotors.p0 < 5'd26 && rotors.p1 < 5'd26 && rotors.p2 < 5'd26)
        else $error("rotor position out of range");

    a_wire_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rotors.w0 <= rlc_pkg::ROT_LAST && rotors.w1 <= rlc_pkg::ROT_LAST &&
        rotors.w2 <= rlc_pkg::ROT_LAST)
        else $error("wiring selection out of range");

    a_fast_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_cfg_we) |=>
        rotors.p0 == (($past(rotors.p0) == 5'd25) ? 5'd0 : $past(rotors.p0) + 5'd1))
        else $error("fast rotor did not step");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_letter < 5'd26)
        else $error("cipher letter out of range");
`endif

endmodule

`default_nettype wire
